// ===== rtl/hrm_pkg.sv =====
package hrm_pkg;

    // Defaults for the map and step counter sizes
    localparam int MAP_ROWS_DEF  = 256;
    localparam int MAP_COLS_DEF  = 256;
    localparam int STEP_BITS_DEF = 12;

    // Angles in 1/128 degree
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;

    // CORDIC start value and unit, Q16
    localparam int CORDIC_GAIN = 39797;
    localparam int ONE_Q16     = 65536;

    localparam int QUEUE_DEPTH = 4;

    // Item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRACE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_EYE_X      = 3'd0;
    localparam logic [2:0] REG_EYE_Y      = 3'd1;
    localparam logic [2:0] REG_EYE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_MAX_STEPS  = 3'd3;
    localparam logic [2:0] REG_AZ_START   = 3'd4;
    localparam logic [2:0] REG_AZ_STEP    = 3'd5;
    localparam logic [2:0] REG_EL_START   = 3'd6;
    localparam logic [2:0] REG_EL_STEP    = 3'd7;

    localparam logic [11:0] MAX_STEPS_RESET = 12'd1024;

    typedef struct packed {
        logic        [15:0] eye_x;
        logic        [15:0] eye_y;
        logic signed [23:0] eye_height;
        logic        [11:0] max_steps;
        logic signed [16:0] az_start;
        logic signed [16:0] az_step;
        logic signed [14:0] el_start;
        logic signed [14:0] el_step;
    } cfg_t;

    // One classified item on its way to the marcher
    typedef struct packed {
        logic               action;
        logic        [7:0]  cell_row;
        logic        [7:0]  cell_col;
        logic signed [15:0] cell_height;
        logic signed [30:0] az;
        logic signed [28:0] el;
        logic               column_start;
    } entry_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WRAP,
        B_FOLD,
        B_ROT,
        B_SETUP,
        B_MUL,
        B_TIP,
        B_CHK,
        B_RD,
        B_MIX,
        B_ZED,
        B_CMP,
        B_DONE
    } back_state_t;

    // atan(2^-k) in 1/32768 degree
    function automatic logic signed [23:0] atan_val(input logic [3:0] k);
        logic signed [23:0] v;
        case (k)
            4'd0:    v = 24'sd1474560;
            4'd1:    v = 24'sd870484;
            4'd2:    v = 24'sd459940;
            4'd3:    v = 24'sd233473;
            4'd4:    v = 24'sd117189;
            4'd5:    v = 24'sd58653;
            4'd6:    v = 24'sd29333;
            4'd7:    v = 24'sd14667;
            4'd8:    v = 24'sd7334;
            4'd9:    v = 24'sd3667;
            4'd10:   v = 24'sd1833;
            4'd11:   v = 24'sd917;
            4'd12:   v = 24'sd458;
            4'd13:   v = 24'sd229;
            4'd14:   v = 24'sd115;
            default: v = 24'sd57;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hrm_front.sv =====
module hrm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  hrm_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         cell_row,
    input  logic [7:0]         cell_col,
    input  logic signed [15:0] cell_height,
    input  logic [11:0]        pixel_col,
    input  logic [11:0]        pixel_row,
    input  logic               column_start,
    input  logic               q_full,
    output logic               q_push,
    output hrm_pkg::entry_t    q_wdata
);
    import hrm_pkg::*;

    logic               stg_valid_reg;
    logic               stg_valid_next;
    logic               stg_action_reg;
    logic [7:0]         stg_row_reg;
    logic [7:0]         stg_col_reg;
    logic signed [15:0] stg_height_reg;
    logic [11:0]        stg_pcol_reg;
    logic [11:0]        stg_prow_reg;
    logic               stg_cs_reg;
    logic               accept;

    assign in_ready = !stg_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = stg_valid_reg && !q_full;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (q_push)
        begin
            stg_valid_next = 1'b0;
        end
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_action_reg <= action;
            stg_row_reg    <= cell_row;
            stg_col_reg    <= cell_col;
            stg_height_reg <= cell_height;
            stg_pcol_reg   <= pixel_col;
            stg_prow_reg   <= pixel_row;
            stg_cs_reg     <= column_start;
        end
    end

    // Form the ray angles: start plus index times step
    always_comb
    begin
        q_wdata.action       = stg_action_reg;
        q_wdata.cell_row     = stg_row_reg;
        q_wdata.cell_col     = stg_col_reg;
        q_wdata.cell_height  = stg_height_reg;
        q_wdata.az           = 31'(cfg.az_start)
                             + $signed({1'b0, stg_pcol_reg}) * cfg.az_step;
        q_wdata.el           = 29'(cfg.el_start)
                             + $signed({1'b0, stg_prow_reg}) * cfg.el_step;
        q_wdata.column_start = stg_cs_reg;
    end

endmodule

// ===== rtl/hrm_queue.sv =====
module hrm_queue #(
    parameter int DEPTH = hrm_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hrm_pkg::entry_t wdata,
    output logic            full,
    input  logic            pop,
    output hrm_pkg::entry_t rdata,
    output logic            empty
);
    import hrm_pkg::*;

    localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t          slot_reg [DEPTH];
    logic [PB-1:0]   wr_ptr_reg;
    logic [PB-1:0]   rd_ptr_reg;
    logic [PB:0]     count_reg;
    logic [PB:0]     count_next;

    assign full  = (count_reg == (PB+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PB'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PB'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/hrm_back.sv =====
module hrm_back #(
    parameter int MAP_ROWS  = hrm_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS  = hrm_pkg::MAP_COLS_DEF,
    parameter int STEP_BITS = hrm_pkg::STEP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hrm_pkg::cfg_t      cfg,
    input  hrm_pkg::entry_t    q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_hit,
    output logic [11:0]        out_step,
    output logic [7:0]         out_row,
    output logic [7:0]         out_col,
    output logic signed [23:0] out_height
);
    import hrm_pkg::*;

    localparam int RB  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int CB  = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int AW  = RB + CB;
    localparam int PW  = STEP_BITS + 19;
    localparam int TW  = PW + 1;
    localparam int TZW = PW + 6;
    localparam int ZW  = 38;
    localparam int CW  = ((TZW > ZW) ? TZW : ZW) + 1;
    localparam logic [16:0] STEP_MAX = 17'((1 << STEP_BITS) - 1);
    localparam logic signed [TW:0] COLS_S = (TW+1)'(MAP_COLS);
    localparam logic signed [TW:0] ROWS_S = (TW+1)'(MAP_ROWS);

    back_state_t state_reg;
    back_state_t state_next;

    entry_t                 item_reg;
    logic                   sel_el_reg;
    logic [3:0]             cnt_reg;
    logic [29:0]            mag_reg;
    logic                   ang_neg_reg;
    logic signed [19:0]     cx_reg;
    logic signed [19:0]     cy_reg;
    logic signed [23:0]     cz_reg;
    logic                   fneg_reg;
    logic signed [17:0]     dx_reg;
    logic signed [17:0]     dy_reg;
    logic signed [17:0]     dz_reg;
    logic [STEP_BITS-1:0]   d_reg;
    logic signed [PW-1:0]   px_reg;
    logic signed [PW-1:0]   py_reg;
    logic signed [PW-1:0]   pz_reg;
    logic signed [TW-1:0]   tx_reg;
    logic signed [TW-1:0]   ty_reg;
    logic signed [TZW-1:0]  tz_reg;
    logic [CB-1:0]          xf_reg;
    logic [CB-1:0]          xc_reg;
    logic [RB-1:0]          yf_reg;
    logic [RB-1:0]          yc_reg;
    logic [7:0]             fx_reg;
    logic [7:0]             fy_reg;
    logic [7:0]             row8_reg;
    logic [7:0]             col8_reg;
    logic signed [15:0]     h00_reg;
    logic signed [15:0]     h01_reg;
    logic signed [15:0]     h10_reg;
    logic signed [15:0]     h11_reg;
    logic signed [26:0]     top_reg;
    logic signed [26:0]     bot_reg;
    logic signed [ZW-1:0]   z_reg;
    logic                   res_hit_reg;
    logic [11:0]            res_step_reg;
    logic [7:0]             res_row_reg;
    logic [7:0]             res_col_reg;
    logic signed [23:0]     res_height_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [11:0]            out_step_reg;
    logic [7:0]             out_row_reg;
    logic [7:0]             out_col_reg;
    logic signed [23:0]     out_height_reg;

    logic signed [15:0]     map_mem [2**AW];
    logic signed [15:0]     mem_q;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   mem_we;
    logic [31:0]            ld_row;
    logic [31:0]            ld_col;

    logic [16:0]            limit17;
    logic [16:0]            d17;
    logic [16:0]            base17;
    logic [29:0]            wrap_sub;
    logic signed [16:0]     a_mod;
    logic signed [16:0]     a_half;
    logic signed [16:0]     a_fold;
    logic                   fold_neg;
    logic signed [19:0]     xs;
    logic signed [19:0]     ys;
    logic signed [19:0]     nx;
    logic signed [19:0]     ny;
    logic signed [23:0]     nz;
    logic signed [17:0]     cl_x;
    logic signed [17:0]     cl_y;
    logic signed [PW+4:0]   pz20;
    logic signed [TW-1:0]   xf_s;
    logic signed [TW-1:0]   yf_s;
    logic signed [TW:0]     xc_s;
    logic signed [TW:0]     yc_s;
    logic                   off_map;
    logic [8:0]             wx0;
    logic [8:0]             wy0;
    logic signed [ZW-1:0]   zsum;
    logic                   hit_now;
    logic                   out_free;
    logic [29:0]            el_mag;
    logic signed [30:0]     el_ext;

    function automatic logic signed [17:0] clamp_q16(input logic signed [19:0] v);
        logic signed [17:0] r;
        if (v > 20'sd65536)
        begin
            r = 18'sd65536;
        end
        else if (v < -20'sd65536)
        begin
            r = -18'sd65536;
        end
        else
        begin
            r = 18'(v);
        end
        return r;
    endfunction

    // Step limit and distances in a common width
    assign limit17  = ({5'b0, cfg.max_steps} > STEP_MAX) ? STEP_MAX : {5'b0, cfg.max_steps};
    assign d17      = 17'(d_reg);
    assign base17   = item_reg.column_start ? 17'd0 : d17;
    assign out_free = !out_valid_reg || out_ready;

    // Angle wrap: restoring reduction of the magnitude, one shift a cycle
    assign wrap_sub = 30'(FULL_TURN) << cnt_reg;
    assign a_mod    = (ang_neg_reg && (mag_reg != '0)) ? 17'(FULL_TURN) - 17'(mag_reg)
                                                       : 17'(mag_reg);
    assign a_half   = (a_mod >= 17'(HALF_TURN)) ? a_mod - 17'(FULL_TURN) : a_mod;

    always_comb
    begin
        fold_neg = 1'b0;
        a_fold   = a_half;
        if (a_half > 17'(QUARTER_TURN))
        begin
            a_fold   = a_half - 17'(HALF_TURN);
            fold_neg = 1'b1;
        end
        else if (a_half < -17'(QUARTER_TURN))
        begin
            a_fold   = a_half + 17'(HALF_TURN);
            fold_neg = 1'b1;
        end
    end

    // One CORDIC rotation
    always_comb
    begin
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        if (cz_reg >= 0)
        begin
            nx = cx_reg - ys;
            ny = cy_reg + xs;
            nz = cz_reg - atan_val(cnt_reg);
        end
        else
        begin
            nx = cx_reg + ys;
            ny = cy_reg - xs;
            nz = cz_reg + atan_val(cnt_reg);
        end
    end

    assign cl_x   = clamp_q16(nx);
    assign cl_y   = clamp_q16(ny);
    assign el_ext = 31'(item_reg.el);
    assign el_mag = el_ext[30] ? 30'(-el_ext) : 30'(el_ext);

    // Ray tip and map bounds
    assign pz20    = ((PW+5)'(pz_reg) <<< 4) + ((PW+5)'(pz_reg) <<< 2);
    assign xf_s    = tx_reg >>> 8;
    assign yf_s    = ty_reg >>> 8;
    assign xc_s    = (TW+1)'(xf_s) + $signed({{TW{1'b0}}, |tx_reg[7:0]});
    assign yc_s    = (TW+1)'(yf_s) + $signed({{TW{1'b0}}, |ty_reg[7:0]});
    assign off_map = xf_s[TW-1] || yf_s[TW-1] || (xc_s >= COLS_S) || (yc_s >= ROWS_S);

    // Bilinear weights
    assign wx0  = 9'd256 - {1'b0, fx_reg};
    assign wy0  = 9'd256 - {1'b0, fy_reg};
    assign zsum = top_reg * $signed({1'b0, wy0}) + bot_reg * $signed({2'b0, fy_reg});
    assign hit_now = CW'(z_reg) >= CW'(tz_reg);

    // Map port
    assign ld_row  = 32'(q_data.cell_row);
    assign ld_col  = 32'(q_data.cell_col);
    assign wr_addr = {ld_row[RB-1:0], ld_col[CB-1:0]};
    assign mem_we  = q_pop && (q_data.action == ACT_LOAD)
                     && (ld_row < 32'(MAP_ROWS)) && (ld_col < 32'(MAP_COLS));

    always_comb
    begin
        case (cnt_reg)
            4'd0:    rd_addr = {yf_reg, xf_reg};
            4'd1:    rd_addr = {yf_reg, xc_reg};
            4'd2:    rd_addr = {yc_reg, xf_reg};
            default: rd_addr = {yc_reg, xc_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr] <= q_data.cell_height;
        end
        mem_q <= map_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.action == ACT_TRACE)
                    begin
                        state_next = B_WRAP;
                    end
                end
            end
            B_WRAP:  if (cnt_reg == 4'd0) state_next = B_FOLD;
            B_FOLD:  state_next = B_ROT;
            B_ROT:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = sel_el_reg ? B_SETUP : B_WRAP;
                end
            end
            B_SETUP: state_next = (base17 >= limit17) ? B_DONE : B_MUL;
            B_MUL:   state_next = B_TIP;
            B_TIP:   state_next = B_CHK;
            B_CHK:   state_next = off_map ? B_DONE : B_RD;
            B_RD:    if (cnt_reg == 4'd4) state_next = B_MIX;
            B_MIX:   state_next = B_ZED;
            B_ZED:   state_next = B_CMP;
            B_CMP:
            begin
                if (hit_now || ((d17 + 17'd1) >= limit17))
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_MUL;
                end
            end
            B_DONE:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sel_el_reg    <= 1'b0;
            cnt_reg       <= '0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == B_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    cnt_reg    <= 4'd12;
                    sel_el_reg <= 1'b0;
                end
                B_WRAP:  if (cnt_reg != 4'd0) cnt_reg <= cnt_reg - 1'b1;
                B_FOLD:  cnt_reg <= 4'd0;
                B_ROT:
                begin
                    if ((cnt_reg == 4'd15) && !sel_el_reg)
                    begin
                        sel_el_reg <= 1'b1;
                        cnt_reg    <= 4'd12;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                B_SETUP: if (item_reg.column_start) d_reg <= '0;
                B_CHK:
                begin
                    cnt_reg <= 4'd0;
                    if (off_map)
                    begin
                        d_reg <= STEP_BITS'(limit17);
                    end
                end
                B_RD:    cnt_reg <= cnt_reg + 1'b1;
                B_CMP:   if (!hit_now) d_reg <= STEP_BITS'(d17 + 17'd1);
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                item_reg    <= q_data;
                ang_neg_reg <= q_data.az[30];
                mag_reg     <= q_data.az[30] ? 30'(-q_data.az) : 30'(q_data.az);
            end
            B_WRAP:  if (mag_reg >= wrap_sub) mag_reg <= mag_reg - wrap_sub;
            B_FOLD:
            begin
                cx_reg   <= 20'(CORDIC_GAIN);
                cy_reg   <= '0;
                cz_reg   <= 24'(a_fold) <<< 8;
                fneg_reg <= fold_neg;
            end
            B_ROT:
            begin
                cx_reg <= nx;
                cy_reg <= ny;
                cz_reg <= nz;
                if (cnt_reg == 4'd15)
                begin
                    if (!sel_el_reg)
                    begin
                        dx_reg      <= fneg_reg ? -cl_y : cl_y;
                        dy_reg      <= fneg_reg ? -cl_x : cl_x;
                        ang_neg_reg <= el_ext[30];
                        mag_reg     <= el_mag;
                    end
                    else
                    begin
                        dz_reg <= fneg_reg ? -cl_y : cl_y;
                    end
                end
            end
            B_SETUP:
            begin
                res_hit_reg    <= 1'b0;
                res_step_reg   <= '0;
                res_row_reg    <= '0;
                res_col_reg    <= '0;
                res_height_reg <= '0;
            end
            B_MUL:
            begin
                px_reg <= dx_reg * $signed({1'b0, d_reg});
                py_reg <= dy_reg * $signed({1'b0, d_reg});
                pz_reg <= dz_reg * $signed({1'b0, d_reg});
            end
            B_TIP:
            begin
                tx_reg <= $signed(TW'(cfg.eye_x)) + TW'(px_reg >>> 8);
                ty_reg <= $signed(TW'(cfg.eye_y)) + TW'(py_reg >>> 8);
                tz_reg <= TZW'(cfg.eye_height) + TZW'(pz20 >>> 8);
            end
            B_CHK:
            begin
                xf_reg   <= xf_s[CB-1:0];
                yf_reg   <= yf_s[RB-1:0];
                xc_reg   <= xc_s[CB-1:0];
                yc_reg   <= yc_s[RB-1:0];
                fx_reg   <= tx_reg[7:0];
                fy_reg   <= ty_reg[7:0];
                col8_reg <= xf_s[7:0];
                row8_reg <= yf_s[7:0];
            end
            B_RD:
            begin
                case (cnt_reg)
                    4'd1:    h00_reg <= mem_q;
                    4'd2:    h01_reg <= mem_q;
                    4'd3:    h10_reg <= mem_q;
                    4'd4:    h11_reg <= mem_q;
                    default: ;
                endcase
            end
            B_MIX:
            begin
                top_reg <= h00_reg * $signed({1'b0, wx0}) + h01_reg * $signed({2'b0, fx_reg});
                bot_reg <= h10_reg * $signed({1'b0, wx0}) + h11_reg * $signed({2'b0, fx_reg});
            end
            B_ZED:   z_reg <= zsum >>> 8;
            B_CMP:
            begin
                if (hit_now)
                begin
                    res_hit_reg    <= 1'b1;
                    res_step_reg   <= 12'(d_reg);
                    res_row_reg    <= row8_reg;
                    res_col_reg    <= col8_reg;
                    res_height_reg <= z_reg[23:0];
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_hit_reg    <= res_hit_reg;
                    out_step_reg   <= res_step_reg;
                    out_row_reg    <= res_row_reg;
                    out_col_reg    <= res_col_reg;
                    out_height_reg <= res_height_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_step   = out_step_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_height = out_height_reg;

endmodule

// ===== rtl/heightmap_ray_march.sv =====
// Terrain ray marcher over an elevation map held in on-chip memory. Load items
// (tuser 0) write one map cell each; trace items (tuser 1) march a ray for one
// pixel and give one result item each. A trace item first passes through the
// shared angle unit (a 13-step modulo-360 wrap, a fold and 16 CORDIC rotations,
// run once for azimuth and once for elevation), then marches step by step, each
// step paced by the single read port of the map memory (four cell reads a step)
// and the registered multiply stages of the interpolation. Unless column_start
// is set, a ray marches on from the distance left by the previous row of the
// column. The front end registers each item and forms its angles, and a
// four-entry queue lets it keep taking items while the marcher works. Send
// column_start on the first row of each column. The map has no reset: read only
// cells that have been loaded. Write configuration only while the block is idle.
module heightmap_ray_march #(
    parameter int MAP_ROWS  = hrm_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS  = hrm_pkg::MAP_COLS_DEF,
    parameter int STEP_BITS = hrm_pkg::STEP_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_row[7:0], cell_col[15:8], cell_height[31:16], pixel_col[43:32],
    // pixel_row[55:44], column_start[56], zero[63:57]
    input  logic [63:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // march_step[11:0], hit_row[19:12], hit_col[27:20], hit_height[51:28],
    // zero[55:52]
    output logic [55:0] m_axis_tdata,
    // hit[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import hrm_pkg::*;

    cfg_t               cfg_reg;
    entry_t             q_wdata;
    entry_t             q_rdata;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [11:0]        res_step;
    logic [7:0]         res_row;
    logic [7:0]         res_col;
    logic signed [23:0] res_height;

    // Hold configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eye_x      <= '0;
            cfg_reg.eye_y      <= '0;
            cfg_reg.eye_height <= '0;
            cfg_reg.max_steps  <= MAX_STEPS_RESET;
            cfg_reg.az_start   <= '0;
            cfg_reg.az_step    <= '0;
            cfg_reg.el_start   <= '0;
            cfg_reg.el_step    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EYE_X:      cfg_reg.eye_x      <= cfg_wdata[15:0];
                REG_EYE_Y:      cfg_reg.eye_y      <= cfg_wdata[15:0];
                REG_EYE_HEIGHT: cfg_reg.eye_height <= cfg_wdata;
                REG_MAX_STEPS:  cfg_reg.max_steps  <= cfg_wdata[11:0];
                REG_AZ_START:   cfg_reg.az_start   <= cfg_wdata[16:0];
                REG_AZ_STEP:    cfg_reg.az_step    <= cfg_wdata[16:0];
                REG_EL_START:   cfg_reg.el_start   <= cfg_wdata[14:0];
                REG_EL_STEP:    cfg_reg.el_step    <= cfg_wdata[14:0];
                default:        ;
            endcase
        end
    end

    // Accept and classify items, form ray angles
    hrm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser),
        .cell_row     (s_axis_tdata[7:0]),
        .cell_col     (s_axis_tdata[15:8]),
        .cell_height  (s_axis_tdata[31:16]),
        .pixel_col    (s_axis_tdata[43:32]),
        .pixel_row    (s_axis_tdata[55:44]),
        .column_start (s_axis_tdata[56]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // Decouple the front end from the marcher
    hrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Write the map, run the trig and march each ray
    hrm_back #(
        .MAP_ROWS  (MAP_ROWS),
        .MAP_COLS  (MAP_COLS),
        .STEP_BITS (STEP_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_data     (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_hit    (m_axis_tuser),
        .out_step   (res_step),
        .out_row    (res_row),
        .out_col    (res_col),
        .out_height (res_height)
    );

    assign m_axis_tdata = {4'b0, res_height, res_col, res_row, res_step};

endmodule

// ===== rtl/hrm_checker.sv =====
module hrm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // No result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss result with non-zero fields");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind heightmap_ray_march hrm_checker u_hrm_checker (.*);
